// ----- src/posa_pkg.sv -----
package posa_pkg;

	localparam int HANDLE_W    = 10;
	localparam int COUNT_W     = 11;
	localparam int STACK_DEPTH = 1024;
	localparam int STACK_AW    = 10;
	localparam int AVAIL_CAP   = 1024;
	localparam int OPP_W       = 7;
	localparam int MAXP_W      = 5;
	localparam int PAGES_OUT_W = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 7;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic STATUS_DONE     = 1'b0;
	localparam logic STATUS_NO_PAGES = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_OBJECTS_PER_PAGE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAGES        = 1'd1;

	typedef struct packed {
		logic                wr_en;
		logic [STACK_AW-1:0] wr_addr;
		logic [HANDLE_W-1:0] wr_data;
		logic                rd_en;
		logic [STACK_AW-1:0] rd_addr;
	} stack_req_t;

endpackage

// ----- src/posa_intf.sv -----
interface posa_req_if import posa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [HANDLE_W-1:0] free_slot;

	modport source (output valid, output req_type, output free_slot, input ready);
	modport sink (input valid, input req_type, input free_slot, output ready);
endinterface

interface posa_res_if import posa_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   status;
	logic [HANDLE_W-1:0]    alloc_slot;
	logic [COUNT_W-1:0]     objects_in_use;
	logic [COUNT_W-1:0]     free_objects;
	logic [PAGES_OUT_W-1:0] pages_in_use;

	modport source (output valid, output status, output alloc_slot, output objects_in_use,
		output free_objects, output pages_in_use, input ready);
	modport sink (input valid, input status, input alloc_slot, input objects_in_use,
		input free_objects, input pages_in_use, output ready);
endinterface

interface posa_cfg_if import posa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/posa_stack_ram.sv -----
module posa_stack_ram import posa_pkg::*; (
	input  logic                clk,
	input  stack_req_t          req,
	output logic [HANDLE_W-1:0] rd_data
);

	logic [HANDLE_W-1:0] mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

// ----- src/paged_object_slot_allocator_top.sv -----
// Fixed-size object slot allocator. Slots are grouped into pages of objects_per_page slots;
// page 0 is open after reset. An allocate transaction pops the most recently freed handle from
// a 1024-entry LIFO held in a single-port-per-direction synchronous memory, or else takes the
// next unused slot of the newest page, highest index first, opening a new page when needed and
// answering status 1 when the page limit is reached. A free pushes its handle unchecked
// unless the stack is full or free_objects is at AVAIL_CAP. Handles, 10 bits, are
// page * SLOTS_PER_PAGE_MAX + index. Each request yields one result. A free or fresh-page
// allocate goes to the output register; a stack allocate also passes the registered stack
// read and ST_READ. The output register lets a new request in during the cycle its previous
// result is taken. Page size and limit changes take effect when the next page is opened.
module paged_object_slot_allocator_top import posa_pkg::*; #(
	parameter int PAGES_MAX          = 16,
	parameter int SLOTS_PER_PAGE_MAX = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	posa_req_if.sink    req,
	posa_res_if.source  res,
	posa_cfg_if.sink    cfg
);

	localparam int OPW       = $clog2(PAGES_MAX + 1);
	localparam int FRW       = $clog2(SLOTS_PER_PAGE_MAX + 1);
	localparam int FRESH_RST = (4 > SLOTS_PER_PAGE_MAX) ? SLOTS_PER_PAGE_MAX : 4;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic                state_q;
	logic [OPP_W-1:0]    opp_q;
	logic [MAXP_W-1:0]   maxp_q;
	logic [COUNT_W-1:0]  freed_q;
	logic [FRW-1:0]      fresh_q;
	logic [OPW-1:0]      open_q;
	logic [COUNT_W-1:0]  in_use_q;
	logic [COUNT_W-1:0]  avail_q;

	logic                   out_valid_q;
	logic                   out_status_q;
	logic [HANDLE_W-1:0]    out_slot_q;
	logic [COUNT_W-1:0]     out_in_use_q;
	logic [COUNT_W-1:0]     out_avail_q;
	logic [PAGES_OUT_W-1:0] out_pages_q;

	logic                accept;
	logic                pop;
	logic                push;
	logic [FRW-1:0]      page_size;
	logic [OPW-1:0]      page_limit;
	logic                open_new;
	logic                alloc_ok;
	logic [OPW-1:0]      open_n;
	logic [FRW-1:0]      fresh_n;
	logic [COUNT_W-1:0]  avail_base;
	logic [31:0]         slot_calc;
	logic [HANDLE_W-1:0] fresh_slot;
	logic [HANDLE_W-1:0] rd_data;
	stack_req_t          stack_req;

	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || res.ready);
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign pop  = (req.req_type == REQ_ALLOC) && (freed_q != '0);
	assign push = (req.req_type == REQ_FREE) && (32'(freed_q) < STACK_DEPTH)
		&& (32'(avail_q) < AVAIL_CAP);

	always_comb begin
		if (opp_q == '0) begin
			page_size = FRW'(1);
		end else if (32'(opp_q) > SLOTS_PER_PAGE_MAX) begin
			page_size = FRW'(SLOTS_PER_PAGE_MAX);
		end else begin
			page_size = FRW'(opp_q);
		end
		if (maxp_q == '0 || 32'(maxp_q) > PAGES_MAX) begin
			page_limit = OPW'(PAGES_MAX);
		end else begin
			page_limit = OPW'(maxp_q);
		end
		open_new   = (fresh_q == '0) && (open_q < page_limit);
		alloc_ok   = (fresh_q != '0) || open_new;
		open_n     = open_new ? open_q + OPW'(1) : open_q;
		avail_base = open_new ? avail_q + COUNT_W'(page_size) : avail_q;
		fresh_n    = (open_new ? page_size : fresh_q) - FRW'(1);
		slot_calc  = 32'(open_n - OPW'(1)) * 32'(SLOTS_PER_PAGE_MAX) + 32'(fresh_n);
		fresh_slot = slot_calc[HANDLE_W-1:0];
	end

	always_comb begin
		stack_req.wr_en   = accept && push;
		stack_req.wr_addr = freed_q[STACK_AW-1:0];
		stack_req.wr_data = req.free_slot;
		stack_req.rd_en   = accept && pop;
		stack_req.rd_addr = STACK_AW'(freed_q - COUNT_W'(1));
	end

	posa_stack_ram u_stack (
		.clk     (clk),
		.req     (stack_req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opp_q  <= OPP_W'(4);
			maxp_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_OBJECTS_PER_PAGE: opp_q  <= cfg.data[OPP_W-1:0];
				CFG_MAX_PAGES:        maxp_q <= cfg.data[MAXP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			freed_q     <= '0;
			fresh_q     <= FRW'(FRESH_RST);
			open_q      <= OPW'(1);
			in_use_q    <= '0;
			avail_q     <= COUNT_W'(FRESH_RST);
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_READ || (accept && !pop)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (pop) begin
							freed_q  <= freed_q - COUNT_W'(1);
							avail_q  <= avail_q - COUNT_W'(1);
							in_use_q <= in_use_q + COUNT_W'(1);
							state_q  <= ST_READ;
						end else if (req.req_type == REQ_ALLOC && alloc_ok) begin
							open_q   <= open_n;
							fresh_q  <= fresh_n;
							avail_q  <= avail_base - COUNT_W'(1);
							in_use_q <= in_use_q + COUNT_W'(1);
						end else if (push) begin
							freed_q <= freed_q + COUNT_W'(1);
							avail_q <= avail_q + COUNT_W'(1);
							if (in_use_q != '0) begin
								in_use_q <= in_use_q - COUNT_W'(1);
							end
						end
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			out_status_q <= STATUS_DONE;
			out_slot_q   <= rd_data;
			out_in_use_q <= in_use_q;
			out_avail_q  <= avail_q;
			out_pages_q  <= PAGES_OUT_W'(open_q);
		end else if (accept && !pop) begin
			if (req.req_type == REQ_ALLOC && alloc_ok) begin
				out_status_q <= STATUS_DONE;
				out_slot_q   <= fresh_slot;
				out_in_use_q <= in_use_q + COUNT_W'(1);
				out_avail_q  <= avail_base - COUNT_W'(1);
				out_pages_q  <= PAGES_OUT_W'(open_n);
			end else if (req.req_type == REQ_ALLOC) begin
				out_status_q <= STATUS_NO_PAGES;
				out_slot_q   <= '0;
				out_in_use_q <= in_use_q;
				out_avail_q  <= avail_q;
				out_pages_q  <= PAGES_OUT_W'(open_q);
			end else if (push) begin
				out_status_q <= STATUS_DONE;
				out_slot_q   <= '0;
				out_in_use_q <= (in_use_q != '0) ? in_use_q - COUNT_W'(1) : in_use_q;
				out_avail_q  <= avail_q + COUNT_W'(1);
				out_pages_q  <= PAGES_OUT_W'(open_q);
			end else begin
				out_status_q <= STATUS_DONE;
				out_slot_q   <= '0;
				out_in_use_q <= in_use_q;
				out_avail_q  <= avail_q;
				out_pages_q  <= PAGES_OUT_W'(open_q);
			end
		end
	end

	assign res.valid          = out_valid_q;
	assign res.status         = out_status_q;
	assign res.alloc_slot     = out_slot_q;
	assign res.objects_in_use = out_in_use_q;
	assign res.free_objects   = out_avail_q;
	assign res.pages_in_use   = out_pages_q;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top import posa_pkg::*; ();

	localparam int PAGE_LIMIT_MAX = 16;
	localparam int SLOT_STRIDE    = 64;
	localparam int CYCLE_LIMIT    = 400000;

	typedef struct packed {
		logic                   status;
		logic [HANDLE_W-1:0]    alloc_slot;
		logic [COUNT_W-1:0]     objects_in_use;
		logic [COUNT_W-1:0]     free_objects;
		logic [PAGES_OUT_W-1:0] pages_in_use;
	} slot_result_t;

	logic clk = 1'b0;
	logic arst_n;

	posa_req_if req_if ();
	posa_res_if res_if ();
	posa_cfg_if cfg_if ();

	paged_object_slot_allocator_top #(
		.PAGES_MAX         (PAGE_LIMIT_MAX),
		.SLOTS_PER_PAGE_MAX(SLOT_STRIDE)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.res   (res_if),
		.cfg   (cfg_if)
	);

	// allocator state as seen from outside
	logic [OPP_W-1:0]       opp_cfg;
	logic [MAXP_W-1:0]      maxp_cfg;
	logic [HANDLE_W-1:0]    freed_handles [STACK_DEPTH];
	logic [COUNT_W-1:0]     freed_depth;
	logic [OPP_W-1:0]       fresh_left;
	logic [PAGES_OUT_W-1:0] pages_open;
	logic [COUNT_W-1:0]     slots_taken;
	logic [COUNT_W-1:0]     slots_avail;

	slot_result_t        pending_results [$];
	logic [HANDLE_W-1:0] held_handles [$];

	int snd_idle_pct;
	int rcv_stall_pct;
	int mismatch_cnt;
	int cycle_cnt;
	slot_result_t got_r;
	slot_result_t want_r;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [OPP_W-1:0] page_size();
		if (opp_cfg == 0)
			return OPP_W'(1);
		if (opp_cfg > SLOT_STRIDE)
			return OPP_W'(SLOT_STRIDE);
		return opp_cfg;
	endfunction

	function automatic logic [MAXP_W-1:0] page_limit();
		if (maxp_cfg == 0 || maxp_cfg > PAGE_LIMIT_MAX)
			return MAXP_W'(PAGE_LIMIT_MAX);
		return maxp_cfg;
	endfunction

	function automatic slot_result_t predict_request(logic rt, logic [HANDLE_W-1:0] h);
		slot_result_t r;
		r = '0;
		r.status = STATUS_DONE;
		if (rt == REQ_ALLOC) begin
			if (freed_depth != 0) begin
				freed_depth = freed_depth - 1'b1;
				r.alloc_slot = freed_handles[freed_depth[STACK_AW-1:0]];
				slots_avail = slots_avail - 1'b1;
				slots_taken = slots_taken + 1'b1;
			end else if (fresh_left == 0 && pages_open >= page_limit()) begin
				r.status = STATUS_NO_PAGES;
			end else begin
				if (fresh_left == 0) begin
					pages_open = pages_open + 1'b1;
					fresh_left = page_size();
					slots_avail = slots_avail + fresh_left;
				end
				fresh_left = fresh_left - 1'b1;
				r.alloc_slot = HANDLE_W'((pages_open - 1) * SLOT_STRIDE + fresh_left);
				slots_avail = slots_avail - 1'b1;
				slots_taken = slots_taken + 1'b1;
			end
		end else if (freed_depth < STACK_DEPTH && slots_avail < AVAIL_CAP) begin
			freed_handles[freed_depth[STACK_AW-1:0]] = h;
			freed_depth = freed_depth + 1'b1;
			slots_avail = slots_avail + 1'b1;
			if (slots_taken != 0)
				slots_taken = slots_taken - 1'b1;
		end
		r.objects_in_use = slots_taken;
		r.free_objects   = slots_avail;
		r.pages_in_use   = pages_open;
		return r;
	endfunction

	task automatic note_mismatch(string what, int want, int got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	always @(negedge clk) begin
		res_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("paged_object_slot_allocator_top regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			got_r.status         = res_if.status;
			got_r.alloc_slot     = res_if.alloc_slot;
			got_r.objects_in_use = res_if.objects_in_use;
			got_r.free_objects   = res_if.free_objects;
			got_r.pages_in_use   = res_if.pages_in_use;
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result, alloc_slot", -1, got_r.alloc_slot);
			end else begin
				want_r = pending_results.pop_front();
				if (got_r.status !== want_r.status)
					note_mismatch("status", want_r.status, got_r.status);
				if (got_r.alloc_slot !== want_r.alloc_slot)
					note_mismatch("alloc_slot", want_r.alloc_slot, got_r.alloc_slot);
				if (got_r.objects_in_use !== want_r.objects_in_use)
					note_mismatch("objects_in_use", want_r.objects_in_use, got_r.objects_in_use);
				if (got_r.free_objects !== want_r.free_objects)
					note_mismatch("free_objects", want_r.free_objects, got_r.free_objects);
				if (got_r.pages_in_use !== want_r.pages_in_use)
					note_mismatch("pages_in_use", want_r.pages_in_use, got_r.pages_in_use);
			end
		end
	end

	task automatic send_req(input logic rt, input logic [HANDLE_W-1:0] h);
		slot_result_t r;
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.req_type  <= rt;
		req_if.free_slot <= h;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		r = predict_request(rt, h);
		pending_results.push_back(r);
		if (rt == REQ_ALLOC && r.status == STATUS_DONE)
			held_handles.push_back(r.alloc_slot);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		if (idx == CFG_OBJECTS_PER_PAGE)
			opp_cfg = val[OPP_W-1:0];
		else
			maxp_cfg = val[MAXP_W-1:0];
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic free_held();
		int idx;
		logic [HANDLE_W-1:0] h;
		if (held_handles.size() == 0) begin
			send_req(REQ_ALLOC, HANDLE_W'($urandom));
		end else begin
			idx = $urandom_range(held_handles.size() - 1);
			h = held_handles[idx];
			held_handles.delete(idx);
			send_req(REQ_FREE, h);
		end
	endtask

	// bursts of allocates or of frees of held handles, with some noise mixed in
	task automatic run_traffic(input int n_items);
		int sent;
		int burst;
		int k;
		bit alloc_burst;
		sent = 0;
		while (sent < n_items) begin
			burst = $urandom_range(1, 24);
			alloc_burst = ($urandom_range(99) < 55);
			for (k = 0; k < burst && sent < n_items; k++) begin
				if ($urandom_range(99) < 8)
					send_req(1'($urandom_range(1)), HANDLE_W'($urandom));
				else if (alloc_burst)
					send_req(REQ_ALLOC, HANDLE_W'($urandom));
				else
					free_held();
				sent++;
			end
		end
	endtask

	task automatic test_alloc_free_basic();
		int k;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		for (k = 0; k < 5; k++)
			send_req(REQ_ALLOC, '1);
		send_req(REQ_FREE, 10'd67);
		send_req(REQ_FREE, 10'h3FF);
		send_req(REQ_FREE, 10'h000);
		for (k = 0; k < 4; k++)
			send_req(REQ_ALLOC, '0);
		send_req(REQ_FREE, 10'h155);
		send_req(REQ_FREE, 10'h2AA);
		wait_drained();
	endtask

	task automatic test_page_limit();
		int k;
		write_reg(CFG_MAX_PAGES, 7'd1);
		for (k = 0; k < 5; k++)
			send_req(REQ_ALLOC, HANDLE_W'($urandom));
		wait_drained();
		write_reg(CFG_OBJECTS_PER_PAGE, 7'd0);
		write_reg(CFG_MAX_PAGES, 7'h7F);
		send_req(REQ_ALLOC, HANDLE_W'($urandom));
		send_req(REQ_ALLOC, HANDLE_W'($urandom));
		wait_drained();
	endtask

	task automatic test_traffic_no_idle();
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		write_reg(CFG_OBJECTS_PER_PAGE, 7'd1);
		write_reg(CFG_MAX_PAGES, 7'd6);
		run_traffic(50);
		wait_drained();
	endtask

	task automatic test_traffic_sender_idle();
		snd_idle_pct  = 76;
		rcv_stall_pct = 0;
		write_reg(CFG_OBJECTS_PER_PAGE, 7'd64);
		write_reg(CFG_MAX_PAGES, 7'd0);
		run_traffic(25);
		// hold off until every outstanding result is back
		wait_drained();
		run_traffic(25);
		wait_drained();
	endtask

	task automatic test_traffic_receiver_stall();
		snd_idle_pct  = 0;
		rcv_stall_pct = 76;
		write_reg(CFG_OBJECTS_PER_PAGE, 7'd127);
		write_reg(CFG_MAX_PAGES, CFG_DATA_W'(pages_open + 1'b1));
		run_traffic(50);
		wait_drained();
	endtask

	task automatic test_traffic_both_idle();
		snd_idle_pct  = 23;
		rcv_stall_pct = 23;
		write_reg(CFG_OBJECTS_PER_PAGE, CFG_DATA_W'($urandom_range(1, 8)));
		write_reg(CFG_MAX_PAGES, CFG_DATA_W'($urandom));
		run_traffic(25);
		wait_drained();
		write_reg(CFG_MAX_PAGES, 7'd16);
		run_traffic(25);
		wait_drained();
	endtask

	// drain everything, then fill the freed stack to capacity and pop some back out
	task automatic test_stack_full();
		int k;
		int n_free;
		snd_idle_pct  = 23;
		rcv_stall_pct = 23;
		write_reg(CFG_MAX_PAGES, 7'd1);
		while (freed_depth != 0 || fresh_left != 0)
			send_req(REQ_ALLOC, HANDLE_W'($urandom));
		send_req(REQ_ALLOC, HANDLE_W'($urandom));
		send_req(REQ_ALLOC, HANDLE_W'($urandom));
		held_handles.delete();
		n_free = AVAIL_CAP - slots_avail + 2;
		for (k = 0; k < n_free; k++)
			send_req(REQ_FREE, HANDLE_W'($urandom));
		for (k = 0; k < 16; k++)
			send_req(REQ_ALLOC, HANDLE_W'($urandom));
		send_req(REQ_ALLOC, HANDLE_W'($urandom));
		wait_drained();
	endtask

	initial begin
		arst_n           = 1'b0;
		req_if.valid     = 1'b0;
		req_if.req_type  = REQ_ALLOC;
		req_if.free_slot = '0;
		res_if.ready     = 1'b0;
		cfg_if.valid     = 1'b0;
		cfg_if.index     = CFG_OBJECTS_PER_PAGE;
		cfg_if.data      = '0;
		snd_idle_pct     = 0;
		rcv_stall_pct    = 0;
		mismatch_cnt     = 0;
		cycle_cnt        = 0;
		opp_cfg          = 7'd4;
		maxp_cfg         = '0;
		freed_depth      = '0;
		fresh_left       = page_size();
		pages_open       = PAGES_OUT_W'(1);
		slots_taken      = '0;
		slots_avail      = COUNT_W'(fresh_left);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_alloc_free_basic();
		test_page_limit();
		test_traffic_no_idle();
		test_traffic_sender_idle();
		test_traffic_receiver_stall();
		test_traffic_both_idle();
		test_stack_full();

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0 && pending_results.size() == 0)
			$display("paged_object_slot_allocator_top regression: pass");
		else
			$display("paged_object_slot_allocator_top regression: fail");
		$finish;
	end

endmodule
